@@ hw/rtl/srctok_pkg.sv @@
package srctok_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_OPER     = 3'd1,
    MODE_IDENT    = 3'd2,
    MODE_STRING   = 3'd3,
    MODE_NUM_INT  = 3'd4,
    MODE_NUM_DOT  = 3'd5,
    MODE_NUM_FRAC = 3'd6
  } mode_e;

  localparam logic [5:0] KIND_OP_BASE = 6'd11;
  localparam logic [5:0] KIND_IDENT   = 6'd19;
  localparam logic [5:0] KIND_STRING  = 6'd20;
  localparam logic [5:0] KIND_NUMBER  = 6'd21;
  localparam logic [5:0] KIND_KW_BASE = 6'd22;
  localparam logic [5:0] KIND_EOF     = 6'd38;
  localparam logic [5:0] KIND_ERROR   = 6'd39;

  localparam int KwSlots = 6;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] line;
    logic [31:0] start;
    logic [15:0] len;
    logic [31:0] value;
    logic        frac;
    logic        last;
  } token_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  count;
    token_t [2:0] tok;
  } group_t;

  function automatic logic [4:0] punct_index(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd31;
    case (b)
      8'h28: r = 5'd0;
      8'h29: r = 5'd1;
      8'h7B: r = 5'd2;
      8'h7D: r = 5'd3;
      8'h2C: r = 5'd4;
      8'h2E: r = 5'd5;
      8'h2D: r = 5'd6;
      8'h2B: r = 5'd7;
      8'h3B: r = 5'd8;
      8'h2F: r = 5'd9;
      8'h2A: r = 5'd10;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic [47:0] kw_text(input logic [3:0] k);
    logic [47:0] t;
    case (k)
      4'd0:  t = {"and", 24'h0};
      4'd1:  t = {"class", 8'h0};
      4'd2:  t = {"def", 24'h0};
      4'd3:  t = {"else", 16'h0};
      4'd4:  t = {"false", 8'h0};
      4'd5:  t = {"for", 24'h0};
      4'd6:  t = {"if", 32'h0};
      4'd7:  t = {"nil", 24'h0};
      4'd8:  t = {"or", 32'h0};
      4'd9:  t = {"print", 8'h0};
      4'd10: t = "return";
      4'd11: t = {"super", 8'h0};
      4'd12: t = {"this", 16'h0};
      4'd13: t = {"true", 16'h0};
      4'd14: t = {"var", 24'h0};
      default: t = {"while", 8'h0};
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    case (k)
      4'd0, 4'd2, 4'd5, 4'd7, 4'd14: l = 3'd3;
      4'd1, 4'd4, 4'd9, 4'd11, 4'd15: l = 3'd5;
      4'd3, 4'd12, 4'd13: l = 3'd4;
      4'd6, 4'd8: l = 3'd2;
      default: l = 3'd6;
    endcase
    return l;
  endfunction

endpackage

@@ hw/rtl/srctok_front.sv @@
module srctok_front #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int LINE_BITS       = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [7:0]           source_byte_i,
  input  logic                 final_byte_i,
  output srctok_pkg::group_t   group_o
);

  localparam logic [LINE_BITS-1:0] LineTop = {LINE_BITS{1'b1}};

  srctok_pkg::mode_e mode_q, mode_d;
  logic [1:0]  pop_q, pop_d;
  logic [31:0] pos_q, pos_d, start_q, start_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [7:0]  pfx_q [KEYWORD_MAX_LEN];
  logic [7:0]  pfx_d [KEYWORD_MAX_LEN];
  logic [15:0] len_q, len_d;
  logic [31:0] acc_q, acc_d;
  logic        frac_q, frac_d;
  srctok_pkg::group_t grp_d;

  function automatic logic [31:0] add_digit(input logic [31:0] a, input logic [7:0] b);
    logic [35:0] v;
    v = {4'd0, a} * 36'd10 + {32'd0, b[3:0]};
    return (v[35:32] != 4'd0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  always_comb begin
    logic taken;
    logic [4:0] pi;
    logic [3:0] kidx;
    logic kw_hit;
    logic [47:0] kt;
    logic match;
    logic [1:0] n;
    srctok_pkg::token_t t;
    logic [5:0] wkind;

    mode_d = mode_q;
    pop_d = pop_q;
    pos_d = pos_q;
    start_d = start_q;
    line_d = line_q;
    pfx_d = pfx_q;
    len_d = len_q;
    acc_d = acc_q;
    frac_d = frac_q;
    grp_d = '0;
    n = 2'd0;
    taken = 1'b0;
    t = '0;
    pi = 5'd0;

    kw_hit = 1'b0;
    kidx = 4'd0;
    for (int k = 0; k < 16; k++) begin
      kt = srctok_pkg::kw_text(4'(k));
      match = (len_q == 16'(srctok_pkg::kw_len(4'(k))));
      for (int j = 0; j < srctok_pkg::KwSlots; j++) begin
        if (j < int'(srctok_pkg::kw_len(4'(k))) && j < KEYWORD_MAX_LEN) begin
          if (pfx_q[j] != kt[47-8*j -: 8]) match = 1'b0;
        end
      end
      if (match && !kw_hit) begin
        kw_hit = 1'b1;
        kidx = 4'(k);
      end
    end
    wkind = kw_hit ? srctok_pkg::KIND_KW_BASE + {2'b0, kidx} : srctok_pkg::KIND_IDENT;

    if (push_i) begin
      case (mode_q)
        srctok_pkg::MODE_OPER: begin
          mode_d = srctok_pkg::MODE_IDLE;
          t.kind = srctok_pkg::KIND_OP_BASE + {3'd0, pop_q, 1'b0};
          t.start = start_q;
          t.len = 16'd1;
          if (source_byte_i == 8'h3D) begin
            t.kind = t.kind + 6'd1;
            t.len = 16'd2;
            taken = 1'b1;
          end
          t.line = 16'(line_q);
          grp_d.tok[n] = t; n = n + 2'd1;
        end
        srctok_pkg::MODE_IDENT: begin
          if (srctok_pkg::is_letter(source_byte_i) || source_byte_i == 8'h5F) begin
            taken = 1'b1;
            for (int j = 0; j < KEYWORD_MAX_LEN; j++)
              if (len_q == 16'(j)) pfx_d[j] = source_byte_i;
            if (len_q != 16'hFFFF) len_d = len_q + 16'd1;
          end else begin
            mode_d = srctok_pkg::MODE_IDLE;
            t.kind = wkind; t.start = start_q; t.len = len_q; t.line = 16'(line_q);
            grp_d.tok[n] = t; n = n + 2'd1;
          end
        end
        srctok_pkg::MODE_STRING: begin
          taken = 1'b1;
          if (len_q != 16'hFFFF) len_d = len_q + 16'd1;
          if (source_byte_i == 8'h22) begin
            mode_d = srctok_pkg::MODE_IDLE;
            t.kind = srctok_pkg::KIND_STRING; t.start = start_q; t.len = len_d;
            t.line = 16'(line_q);
            grp_d.tok[n] = t; n = n + 2'd1;
          end else if (source_byte_i == 8'h0A) begin
            if (line_q != LineTop) line_d = line_q + 1'b1;
          end
        end
        srctok_pkg::MODE_NUM_INT, srctok_pkg::MODE_NUM_DOT, srctok_pkg::MODE_NUM_FRAC: begin
          if (srctok_pkg::is_digit(source_byte_i)) begin
            taken = 1'b1;
            if (len_q != 16'hFFFF) len_d = len_q + 16'd1;
            if (mode_q == srctok_pkg::MODE_NUM_INT) acc_d = add_digit(acc_q, source_byte_i);
            else begin
              mode_d = srctok_pkg::MODE_NUM_FRAC;
              frac_d = 1'b1;
            end
          end else if (source_byte_i == 8'h2E && mode_q == srctok_pkg::MODE_NUM_INT) begin
            taken = 1'b1;
            mode_d = srctok_pkg::MODE_NUM_DOT;
            if (len_q != 16'hFFFF) len_d = len_q + 16'd1;
          end else begin
            mode_d = srctok_pkg::MODE_IDLE;
            t.kind = srctok_pkg::KIND_NUMBER; t.start = start_q; t.len = len_q;
            t.value = acc_q; t.frac = frac_q; t.line = 16'(line_q);
            grp_d.tok[n] = t; n = n + 2'd1;
          end
        end
        default: mode_d = srctok_pkg::MODE_IDLE;
      endcase

      if (!taken) begin
        pi = srctok_pkg::punct_index(source_byte_i);
        t = '0;
        t.start = pos_q;
        t.len = 16'd1;
        if (pi != 5'd31) begin
          t.kind = {1'b0, pi}; t.line = 16'(line_q);
          grp_d.tok[n] = t; n = n + 2'd1;
        end else if (source_byte_i == 8'h21 || source_byte_i == 8'h3D ||
                     source_byte_i == 8'h3E || source_byte_i == 8'h3C) begin
          mode_d = srctok_pkg::MODE_OPER; start_d = pos_q; len_d = 16'd1;
          acc_d = '0; frac_d = 1'b0;
          pop_d = (source_byte_i == 8'h21) ? 2'd0 : (source_byte_i == 8'h3D) ? 2'd1 :
                  (source_byte_i == 8'h3E) ? 2'd2 : 2'd3;
        end else if (source_byte_i == 8'h20 || source_byte_i == 8'h09 ||
                     source_byte_i == 8'h0D) begin
        end else if (source_byte_i == 8'h0A) begin
          if (line_q != LineTop) line_d = line_q + 1'b1;
        end else if (source_byte_i == 8'h22) begin
          mode_d = srctok_pkg::MODE_STRING; start_d = pos_q; len_d = 16'd1;
          acc_d = '0; frac_d = 1'b0;
        end else if (srctok_pkg::is_digit(source_byte_i)) begin
          mode_d = srctok_pkg::MODE_NUM_INT; start_d = pos_q; len_d = 16'd1;
          acc_d = {28'd0, source_byte_i[3:0]}; frac_d = 1'b0;
        end else if (srctok_pkg::is_letter(source_byte_i)) begin
          mode_d = srctok_pkg::MODE_IDENT; start_d = pos_q; len_d = 16'd1;
          acc_d = '0; frac_d = 1'b0;
          pfx_d[0] = source_byte_i;
        end else begin
          t.kind = srctok_pkg::KIND_ERROR; t.line = 16'(line_q);
          grp_d.tok[n] = t; n = n + 2'd1;
        end
      end

      if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;

      if (final_byte_i) begin
        t = '0;
        t.start = start_d; t.len = len_d; t.line = 16'(line_d);
        case (mode_d)
          srctok_pkg::MODE_OPER: begin
            t.kind = srctok_pkg::KIND_OP_BASE + {3'd0, pop_d, 1'b0};
            grp_d.tok[n] = t; n = n + 2'd1;
          end
          srctok_pkg::MODE_IDENT: begin
            t.kind = (mode_q == srctok_pkg::MODE_IDENT) ? wkind : srctok_pkg::KIND_IDENT;
            if (mode_q == srctok_pkg::MODE_IDENT && taken) begin
              t.kind = srctok_pkg::KIND_IDENT;
              kw_hit = 1'b0;
              for (int k = 0; k < 16; k++) begin
                kt = srctok_pkg::kw_text(4'(k));
                match = (len_d == 16'(srctok_pkg::kw_len(4'(k))));
                for (int j = 0; j < srctok_pkg::KwSlots; j++)
                  if (j < int'(srctok_pkg::kw_len(4'(k))) && j < KEYWORD_MAX_LEN)
                    if (pfx_d[j] != kt[47-8*j -: 8]) match = 1'b0;
                if (match && !kw_hit) begin
                  kw_hit = 1'b1;
                  t.kind = srctok_pkg::KIND_KW_BASE + 6'(k);
                end
              end
            end else if (mode_q != srctok_pkg::MODE_IDENT) begin
              t.kind = srctok_pkg::KIND_IDENT;
              for (int k = 0; k < 16; k++) begin
                kt = srctok_pkg::kw_text(4'(k));
                if (srctok_pkg::kw_len(4'(k)) == 3'd1 && pfx_d[0] == kt[47:40])
                  t.kind = srctok_pkg::KIND_KW_BASE + 6'(k);
              end
            end
            grp_d.tok[n] = t; n = n + 2'd1;
          end
          srctok_pkg::MODE_NUM_INT, srctok_pkg::MODE_NUM_DOT,
          srctok_pkg::MODE_NUM_FRAC: begin
            t.kind = srctok_pkg::KIND_NUMBER; t.value = acc_d; t.frac = frac_d;
            grp_d.tok[n] = t; n = n + 2'd1;
          end
          default: ;
        endcase
        t = '0;
        t.kind = srctok_pkg::KIND_EOF; t.start = pos_d; t.line = 16'(line_d);
        grp_d.tok[n] = t; n = n + 2'd1;
        mode_d = srctok_pkg::MODE_IDLE;
        pop_d = '0; pos_d = '0; start_d = '0;
        line_d = LINE_BITS'(1);
        for (int j = 0; j < KEYWORD_MAX_LEN; j++) pfx_d[j] = '0;
        len_d = '0; acc_d = '0; frac_d = 1'b0;
      end

      if (n != 2'd0) begin
        grp_d.valid = 1'b1;
        grp_d.tok[n - 2'd1].last = 1'b1;
      end
      grp_d.count = n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= srctok_pkg::MODE_IDLE;
      pop_q <= '0;
      pos_q <= '0;
      start_q <= '0;
      line_q <= LINE_BITS'(1);
      for (int j = 0; j < KEYWORD_MAX_LEN; j++) pfx_q[j] <= '0;
      len_q <= '0;
      acc_q <= '0;
      frac_q <= 1'b0;
      group_o <= '0;
    end else begin
      mode_q <= mode_d;
      pop_q <= pop_d;
      pos_q <= pos_d;
      start_q <= start_d;
      line_q <= line_d;
      pfx_q <= pfx_d;
      len_q <= len_d;
      acc_q <= acc_d;
      frac_q <= frac_d;
      group_o <= grp_d;
    end
  end

endmodule

@@ hw/rtl/srctok_back.sv @@
module srctok_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srctok_pkg::group_t group_i,
  output logic [1:0]         free_o,
  input  logic               pop_i,
  output logic               empty_o,
  output srctok_pkg::token_t tok_o
);

  localparam int Depth = 8;

  srctok_pkg::token_t mem_q [Depth];
  logic [2:0] wr_q, rd_q;
  logic [3:0] cnt_q;
  logic       deq;

  assign empty_o = (cnt_q == 4'd0);
  assign deq = pop_i && !empty_o;
  assign tok_o = mem_q[rd_q];
  assign free_o = (cnt_q <= 4'd2) ? 2'd3 : 2'd0;

  always_ff @(posedge clk_i) begin
    if (group_i.valid) begin
      for (int i = 0; i < 3; i++)
        if (2'(i) < group_i.count) mem_q[wr_q + 3'(i)] <= group_i.tok[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (group_i.valid) wr_q <= wr_q + 3'(group_i.count);
      if (deq) rd_q <= rd_q + 3'd1;
      cnt_q <= cnt_q + (group_i.valid ? 4'(group_i.count) : 4'd0) - 4'(deq);
    end
  end

endmodule

@@ hw/rtl/source_tokenizer.sv @@
// source_tokenizer: streaming byte scanner producing tokens.
// Input queue side: drive source_byte_i / final_byte_i with push; a
// transaction happens on a clock edge with push high and full low.
// Result queue side: while empty is low the oldest token is on the
// result ports; pop takes it.
// Throughput: one byte per cycle while the receiver keeps up. Each byte
// makes zero to three tokens (a flushed pending token, a fresh one, and
// EOF on the final byte).
// A token emitted by a byte passes the classify register, then the result
// queue, before it shows on the result ports and can be popped.
// The front stage registers each byte's token group; the back stage is
// an eight-entry token queue. full rises once more than two tokens wait,
// leaving room for the group in flight and the next one, so a stalled
// receiver throttles input with no token lost.
// Reset clears scanner state (line 1, offset 0) and empties the queue.
// The final byte resets scanner state after EOF so a new source may
// follow directly.
module source_tokenizer #(
  parameter int KEYWORD_MAX_LEN = 6,
  parameter int LINE_BITS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte_i,
  input  logic        final_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [5:0]  token_kind_o,
  output logic [15:0] line_number_o,
  output logic [31:0] start_offset_o,
  output logic [15:0] lexeme_length_o,
  output logic [31:0] number_value_o,
  output logic        has_fraction_o,
  output logic        run_last_o
);

  srctok_pkg::group_t grp;
  srctok_pkg::token_t tok;
  logic [1:0] free;
  logic       acc;

  assign full = (free == 2'd0) || (grp.valid && grp.count > 2'd0 && free != 2'd3);
  assign acc = push && !full;

  srctok_front #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(acc),
    .source_byte_i(source_byte_i),
    .final_byte_i(final_byte_i),
    .group_o(grp)
  );

  srctok_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .group_i(grp),
    .free_o(free),
    .pop_i(pop),
    .empty_o(empty),
    .tok_o(tok)
  );

  assign token_kind_o = tok.kind;
  assign line_number_o = tok.line;
  assign start_offset_o = tok.start;
  assign lexeme_length_o = tok.len;
  assign number_value_o = tok.value;
  assign has_fraction_o = tok.frac;
  assign run_last_o = tok.last;

endmodule

@@ hw/rtl/srctok_checker.sv @@
module srctok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [5:0] token_kind_i,
  input logic       run_last_i
);

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> token_kind_i <= srctok_pkg::KIND_ERROR) else $error("kind out of range");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_kind_i == srctok_pkg::KIND_EOF) |-> run_last_i)
    else $error("eof not last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(token_kind_i)))
    else $error("result changed while held");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !full) else $error("full while empty");

endmodule

bind source_tokenizer srctok_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .full(full), .empty(empty),
  .pop(pop), .token_kind_i(token_kind_o), .run_last_i(run_last_o)
);
